/* rtl/hbsag_pkg.sv */
`timescale 1ns / 1ps

package hbsag_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int MAX_ORDER_DEF  = 12;

  localparam int BP_BITS     = 4;
  localparam int STATUS_BITS = 2;
  localparam int APB_DATA    = 32;
  localparam int APB_ADDR    = 5;
  localparam int REG_SEL     = 3;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POWER = 2'd1,
    ST_DONE      = 2'd2
  } status_t;

  localparam logic [REG_SEL-1:0] REG_IN_WIDTH    = 3'd0;
  localparam logic [REG_SEL-1:0] REG_IN_HEIGHT   = 3'd1;
  localparam logic [REG_SEL-1:0] REG_BLOCK_POWER = 3'd2;
  localparam logic [REG_SEL-1:0] REG_OUT_WIDTH   = 3'd3;
  localparam logic [REG_SEL-1:0] REG_OUT_HEIGHT  = 3'd4;

endpackage

/* rtl/hbsag_step_if.sv */
`timescale 1ns / 1ps

interface hbsag_step_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

/* rtl/hbsag_addr_if.sv */
`timescale 1ns / 1ps

interface hbsag_addr_if #(
  parameter int COORD_BITS = hbsag_pkg::COORD_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [COORD_BITS-1:0]   src_x;
  logic [COORD_BITS-1:0]   src_y;
  logic [COORD_BITS-1:0]   dst_x;
  logic [COORD_BITS-1:0]   dst_y;
  hbsag_pkg::status_t      status;
  logic                    last;

  modport source (output valid, output src_x, output src_y, output dst_x, output dst_y,
                  output status, output last, input ready);
  modport sink (input valid, input src_x, input src_y, input dst_x, input dst_y,
                input status, input last, output ready);
endinterface

/* rtl/hbsag_curve.sv */
`timescale 1ns / 1ps

module hbsag_curve #(
  parameter int MAX_ORDER = hbsag_pkg::MAX_ORDER_DEF,
  localparam int KW = $clog2(MAX_ORDER + 1)
) (
  input  logic [2*MAX_ORDER-1:0] idx,
  input  logic [KW-1:0]          order,
  output logic [MAX_ORDER-1:0]   x,
  output logic [MAX_ORDER-1:0]   y
);

  logic [MAX_ORDER-1:0] rx;
  logic [MAX_ORDER-1:0] ry;
  logic [MAX_ORDER-1:0] sw;
  logic [MAX_ORDER-1:0] iv;
  logic [MAX_ORDER-1:0] sw_above;
  logic [MAX_ORDER-1:0] iv_above;
  logic [MAX_ORDER-1:0] a;
  logic [MAX_ORDER-1:0] b;

  // per level quadrant digit and the swap / mirror it applies to lower levels
  always_comb begin
    for (int j = 0; j < MAX_ORDER; j++) begin
      rx[j] = idx[2*j+1];
      ry[j] = idx[2*j] ^ idx[2*j+1];
      sw[j] = (j < 32'(order)) && !ry[j];
      iv[j] = sw[j] && rx[j];
    end
  end

  // each output bit sees the combined transform of all levels above it
  always_comb begin
    for (int i = 0; i < MAX_ORDER; i++) begin
      sw_above[i] = ^(sw >> (i + 1));
      iv_above[i] = ^(iv >> (i + 1));
      a[i] = rx[i] ^ iv_above[i];
      b[i] = ry[i] ^ iv_above[i];
      x[i] = sw_above[i] ? b[i] : a[i];
      y[i] = sw_above[i] ? a[i] : b[i];
    end
  end

endmodule

/* rtl/hilbert_block_scan_address_generator_unit.sv */
`timescale 1ns / 1ps

// hilbert block scan address generator
// in_if: one transfer per pixel step; restart high rewinds the scan to its first pixel
// out_if: one transfer per step with the source pixel (hilbert order inside each
//   block, blocks in row-major order), the raster destination pixel, a status code
//   and a last flag on the final pixel of the scan
// apb port: in_width, in_height, block_power, out_width, out_height at 4*index;
//   written by the user only while no step is in flight; the block does not check
// latency: the result of a step is presented the cycle after its input transfer
// throughput: one step per cycle when not stalled; position update and curve decode
//   are one combinational pass between the scan position and output registers
// reset: dimensions return to 1, block power to 0, scan position to the origin,
//   output register empty
// stall: the output register holds its result while out_if.ready is low, and
//   in_if.ready stays high only while that register is empty or being drained
module hilbert_block_scan_address_generator_unit #(
  parameter int COORD_BITS = hbsag_pkg::COORD_BITS_DEF,
  parameter int MAX_ORDER  = hbsag_pkg::MAX_ORDER_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  hbsag_step_if.sink                       in_if,
  hbsag_addr_if.source                     out_if,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hbsag_pkg::APB_ADDR-1:0]   paddr,
  input  logic [hbsag_pkg::APB_DATA-1:0]   pwdata,
  output logic [hbsag_pkg::APB_DATA-1:0]   prdata,
  output logic                             pready
);

  localparam int DW = COORD_BITS + 1;
  localparam int SW = DW + 2;
  localparam int IW = 2 * MAX_ORDER;
  localparam int KW = $clog2(MAX_ORDER + 1);
  localparam int MW = $clog2(DW);
  localparam int HW = (MAX_ORDER > COORD_BITS) ? MAX_ORDER : COORD_BITS;
  localparam int BPW = hbsag_pkg::BP_BITS;

  // configuration registers
  logic [DW-1:0]  in_width_r;
  logic [DW-1:0]  in_height_r;
  logic [BPW-1:0] block_power_r;
  logic [DW-1:0]  out_width_r;
  logic [DW-1:0]  out_height_r;

  logic                                 cfg_wr;
  logic [hbsag_pkg::REG_SEL-1:0]        reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = paddr[hbsag_pkg::APB_ADDR-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r    <= DW'(1);
      in_height_r   <= DW'(1);
      block_power_r <= '0;
      out_width_r   <= DW'(1);
      out_height_r  <= DW'(1);
    end else if (cfg_wr) begin
      case (reg_sel)
        hbsag_pkg::REG_IN_WIDTH:    in_width_r    <= pwdata[DW-1:0];
        hbsag_pkg::REG_IN_HEIGHT:   in_height_r   <= pwdata[DW-1:0];
        hbsag_pkg::REG_BLOCK_POWER: block_power_r <= pwdata[BPW-1:0];
        hbsag_pkg::REG_OUT_WIDTH:   out_width_r   <= pwdata[DW-1:0];
        hbsag_pkg::REG_OUT_HEIGHT:  out_height_r  <= pwdata[DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      hbsag_pkg::REG_IN_WIDTH:    prdata = hbsag_pkg::APB_DATA'(in_width_r);
      hbsag_pkg::REG_IN_HEIGHT:   prdata = hbsag_pkg::APB_DATA'(in_height_r);
      hbsag_pkg::REG_BLOCK_POWER: prdata = hbsag_pkg::APB_DATA'(block_power_r);
      hbsag_pkg::REG_OUT_WIDTH:   prdata = hbsag_pkg::APB_DATA'(out_width_r);
      hbsag_pkg::REG_OUT_HEIGHT:  prdata = hbsag_pkg::APB_DATA'(out_height_r);
      default:                    prdata = '0;
    endcase
  end

  // scan position
  logic [COORD_BITS-1:0] origin_x_r, origin_x_nxt;
  logic [COORD_BITS-1:0] origin_y_r, origin_y_nxt;
  logic [IW-1:0]         curve_index_r, curve_index_nxt;
  logic [COORD_BITS-1:0] out_col_r, out_col_nxt;
  logic [COORD_BITS-1:0] out_row_r, out_row_nxt;
  logic                  scan_done_r, scan_done_nxt;

  // output register
  logic                  out_valid_r;
  logic [COORD_BITS-1:0] src_x_r, src_x_nxt;
  logic [COORD_BITS-1:0] src_y_r, src_y_nxt;
  logic [COORD_BITS-1:0] dst_x_r, dst_x_nxt;
  logic [COORD_BITS-1:0] dst_y_r, dst_y_nxt;
  hbsag_pkg::status_t    status_r, status_nxt;
  logic                  last_r, last_nxt;

  logic in_fire;
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;

  // clamped dimensions and curve order
  logic [DW-1:0] lim, w, h, ow, oh, n;
  logic [MW-1:0] msb;
  logic [KW-1:0] k0, k;
  logic          bp_nz, bad_power, no_src;
  logic [DW-1:0] side, side_m1;
  logic [IW-1:0] last_idx;

  always_comb begin
    lim = {1'b1, {COORD_BITS{1'b0}}};
    w   = (in_width_r   > lim) ? lim : in_width_r;
    h   = (in_height_r  > lim) ? lim : in_height_r;
    ow  = (out_width_r  > lim) ? lim : out_width_r;
    oh  = (out_height_r > lim) ? lim : out_height_r;
    n   = (w < h) ? w : h;
    msb = '0;
    for (int i = 0; i < DW; i++) begin
      if (n[i]) msb = MW'(i);
    end
    k0        = (32'(msb) > MAX_ORDER) ? KW'(MAX_ORDER) : KW'(msb);
    bp_nz     = block_power_r != '0;
    bad_power = bp_nz && ((32'(block_power_r) > MAX_ORDER) || (n == '0)
                          || (32'(block_power_r) > 32'(msb)));
    no_src    = !bp_nz && (n == '0);
    k         = bp_nz ? KW'(block_power_r) : k0;
    side      = DW'(1) << k;
    side_m1   = side - DW'(1);
    last_idx  = ~({IW{1'b1}} << {k, 1'b0});
  end

  // position after an optional restart
  logic [COORD_BITS-1:0] cur_ox, cur_oy, cur_col, cur_row;
  logic [IW-1:0]         cur_idx;
  logic                  cur_done;

  always_comb begin
    cur_ox   = in_if.restart ? '0 : origin_x_r;
    cur_oy   = in_if.restart ? '0 : origin_y_r;
    cur_idx  = in_if.restart ? '0 : curve_index_r;
    cur_col  = in_if.restart ? '0 : out_col_r;
    cur_row  = in_if.restart ? '0 : out_row_r;
    cur_done = in_if.restart ? 1'b0 : scan_done_r;
  end

  logic [MAX_ORDER-1:0] cx, cy;

  hbsag_curve #(
    .MAX_ORDER (MAX_ORDER)
  ) u_curve (
    .idx   (cur_idx),
    .order (k),
    .x     (cx),
    .y     (cy)
  );

  logic          pos_ok, end_src, end_dst;
  logic [HW-1:0] sx_sum, sy_sum;

  always_comb begin
    pos_ok = !cur_done && (ow != '0) && (oh != '0)
             && (DW'(cur_col) < ow) && (DW'(cur_row) < oh)
             && ((cur_idx >> {k, 1'b0}) == '0)
             && ((cur_ox & side_m1[COORD_BITS-1:0]) == '0)
             && ((cur_oy & side_m1[COORD_BITS-1:0]) == '0)
             && (SW'(cur_ox) + SW'(side) <= SW'(w))
             && (SW'(cur_oy) + SW'(side) <= SW'(h))
             && (bp_nz || ((cur_ox | cur_oy) == '0));

    sx_sum = HW'(cx) + HW'(cur_ox);
    sy_sum = HW'(cy) + HW'(cur_oy);

    origin_x_nxt    = cur_ox;
    origin_y_nxt    = cur_oy;
    curve_index_nxt = cur_idx;
    out_col_nxt     = cur_col;
    out_row_nxt     = cur_row;
    scan_done_nxt   = cur_done;
    end_src         = 1'b0;
    end_dst         = 1'b0;

    src_x_nxt  = '0;
    src_y_nxt  = '0;
    dst_x_nxt  = '0;
    dst_y_nxt  = '0;
    last_nxt   = 1'b0;
    status_nxt = hbsag_pkg::ST_OK;

    if (bad_power) begin
      status_nxt = hbsag_pkg::ST_BAD_POWER;
    end else if (no_src) begin
      status_nxt = hbsag_pkg::ST_DONE;
    end else if (!pos_ok) begin
      status_nxt    = hbsag_pkg::ST_DONE;
      scan_done_nxt = 1'b1;
    end else begin
      src_x_nxt = sx_sum[COORD_BITS-1:0];
      src_y_nxt = sy_sum[COORD_BITS-1:0];
      dst_x_nxt = cur_col;
      dst_y_nxt = cur_row;

      // source walk: next curve index, next block along the row, next block row
      if (cur_idx != last_idx) begin
        curve_index_nxt = cur_idx + IW'(1);
      end else if (!bp_nz) begin
        end_src = 1'b1;
      end else if (SW'(cur_ox) + SW'({side, 1'b0}) <= SW'(w)) begin
        curve_index_nxt = '0;
        origin_x_nxt    = cur_ox + side[COORD_BITS-1:0];
      end else if (SW'(cur_oy) + SW'({side, 1'b0}) <= SW'(h)) begin
        curve_index_nxt = '0;
        origin_x_nxt    = '0;
        origin_y_nxt    = cur_oy + side[COORD_BITS-1:0];
      end else begin
        end_src = 1'b1;
      end

      // raster destination walk
      if (DW'(cur_col) + DW'(1) < ow) begin
        out_col_nxt = cur_col + COORD_BITS'(1);
      end else if (DW'(cur_row) + DW'(1) < oh) begin
        out_col_nxt = '0;
        out_row_nxt = cur_row + COORD_BITS'(1);
      end else begin
        end_dst = 1'b1;
      end

      if (end_src || end_dst) begin
        scan_done_nxt = 1'b1;
        last_nxt      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      curve_index_r <= '0;
      out_col_r     <= '0;
      out_row_r     <= '0;
      scan_done_r   <= 1'b0;
    end else if (in_fire) begin
      origin_x_r    <= origin_x_nxt;
      origin_y_r    <= origin_y_nxt;
      curve_index_r <= curve_index_nxt;
      out_col_r     <= out_col_nxt;
      out_row_r     <= out_row_nxt;
      scan_done_r   <= scan_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      src_x_r  <= src_x_nxt;
      src_y_r  <= src_y_nxt;
      dst_x_r  <= dst_x_nxt;
      dst_y_r  <= dst_y_nxt;
      status_r <= status_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_if.valid  = out_valid_r;
  assign out_if.src_x  = src_x_r;
  assign out_if.src_y  = src_y_r;
  assign out_if.dst_x  = dst_x_r;
  assign out_if.dst_y  = dst_y_r;
  assign out_if.status = status_r;
  assign out_if.last   = last_r;

  // a step that is not a pixel carries no coordinates
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != hbsag_pkg::ST_OK) |->
      (src_x_r == '0) && (src_y_r == '0) && (dst_x_r == '0) && (dst_y_r == '0) && !last_r)
    else $error("non-pixel status with nonzero fields");

  // the final pixel leaves the scan finished
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && last_nxt |=> scan_done_r && out_valid_r && last_r)
    else $error("last step did not finish the scan");

  // scan position moves only on an input transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(curve_index_r) && $stable(out_col_r) && $stable(out_row_r)
                 && $stable(scan_done_r))
    else $error("scan position changed without a transfer");

  // a rewind always leaves the scan unfinished unless its first step is last or reports done
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_if.restart && !last_nxt && (status_nxt != hbsag_pkg::ST_DONE)
      |=> !scan_done_r)
    else $error("restart left the scan finished");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

typedef struct packed {
  logic [11:0]         src_x;
  logic [11:0]         src_y;
  logic [11:0]         dst_x;
  logic [11:0]         dst_y;
  hbsag_pkg::status_t  status;
  logic                last;
} scan_addr_t;

class scan_tracker;
  logic [12:0] in_w, in_h, out_w, out_h;
  logic [3:0]  blk_pow;
  logic [11:0] org_x, org_y, col, row;
  logic [23:0] curve_pos;
  bit          finished;
  scan_addr_t  owed_addrs[$];
  int          errors, n_steps, n_pixels, n_last, n_bad, n_finished, n_seen;

  function new();
    in_w = 1;
    in_h = 1;
    out_w = 1;
    out_h = 1;
    blk_pow = 0;
    org_x = '0;
    org_y = '0;
    col = '0;
    row = '0;
    curve_pos = '0;
    finished = 0;
  endfunction

  function void set_reg(logic [hbsag_pkg::REG_SEL-1:0] sel, int unsigned value);
    case (sel)
      hbsag_pkg::REG_IN_WIDTH: in_w = value[12:0];
      hbsag_pkg::REG_IN_HEIGHT: in_h = value[12:0];
      hbsag_pkg::REG_BLOCK_POWER: blk_pow = value[3:0];
      hbsag_pkg::REG_OUT_WIDTH: out_w = value[12:0];
      hbsag_pkg::REG_OUT_HEIGHT: out_h = value[12:0];
      default: ;
    endcase
  endfunction

  function int unsigned clamp_dim(logic [12:0] v);
    int unsigned lim;
    lim = 1 << hbsag_pkg::COORD_BITS_DEF;
    return (v > lim) ? lim : 32'(v);
  endfunction

  // d2xy walk, first step of each curve along y for odd orders, along x for even orders
  function void curve_point(int unsigned side, longint unsigned d,
                            output int unsigned x, output int unsigned y);
    int unsigned s, rx, ry, t;
    x = 0;
    y = 0;
    for (s = 1; s < side; s = s << 1) begin
      rx = int'((d >> 1) & 1);
      ry = int'((d ^ rx) & 1);
      if (ry == 0) begin
        if (rx == 1) begin
          x = s - 1 - x;
          y = s - 1 - y;
        end
        t = x;
        x = y;
        y = t;
      end
      x += s * rx;
      y += s * ry;
      d = d >> 2;
    end
  endfunction

  function scan_addr_t next_addr(bit restart);
    scan_addr_t r;
    int unsigned w, h, ow, oh, n, k, side, x0, y0, cx, cy;
    longint unsigned area;
    bit ok, end_src, end_dst;
    r = '0;
    r.status = hbsag_pkg::ST_OK;
    end_src = 0;
    end_dst = 0;
    if (restart) begin
      org_x = '0;
      org_y = '0;
      curve_pos = '0;
      col = '0;
      row = '0;
      finished = 0;
    end
    w = clamp_dim(in_w);
    h = clamp_dim(in_h);
    ow = clamp_dim(out_w);
    oh = clamp_dim(out_h);
    n = (w < h) ? w : h;
    if (blk_pow != 0) begin
      if (blk_pow > hbsag_pkg::MAX_ORDER_DEF || (32'd1 << blk_pow) > n) begin
        r.status = hbsag_pkg::ST_BAD_POWER;
        return r;
      end
      k = blk_pow;
    end else begin
      if (n == 0) begin
        r.status = hbsag_pkg::ST_DONE;
        return r;
      end
      k = 0;
      while (k < hbsag_pkg::MAX_ORDER_DEF && (n >> (k + 1)) != 0) k++;
    end
    side = 1 << k;
    area = longint'(side) * side;
    x0 = org_x;
    y0 = org_y;
    ok = !finished && ow != 0 && oh != 0 && col < ow && row < oh && curve_pos < area
         && (x0 & (side - 1)) == 0 && (y0 & (side - 1)) == 0
         && x0 + side <= w && y0 + side <= h;
    if (blk_pow == 0 && (x0 | y0) != 0) ok = 0;
    if (!ok) begin
      finished = 1;
      r.status = hbsag_pkg::ST_DONE;
      return r;
    end
    curve_point(side, curve_pos, cx, cy);
    r.src_x = 12'(x0 + cx);
    r.src_y = 12'(y0 + cy);
    r.dst_x = col;
    r.dst_y = row;
    if (longint'(curve_pos) + 1 < area) begin
      curve_pos++;
    end else if (blk_pow == 0) begin
      end_src = 1;
    end else if (x0 + 2 * side <= w) begin
      curve_pos = '0;
      org_x = 12'(x0 + side);
    end else if (y0 + 2 * side <= h) begin
      curve_pos = '0;
      org_x = '0;
      org_y = 12'(y0 + side);
    end else begin
      end_src = 1;
    end
    if (col + 1 < ow) begin
      col++;
    end else if (row + 1 < oh) begin
      col = '0;
      row++;
    end else begin
      end_dst = 1;
    end
    if (end_src || end_dst) begin
      finished = 1;
      r.last = 1;
    end
    return r;
  endfunction

  function void take_step(bit restart);
    scan_addr_t a;
    a = next_addr(restart);
    n_steps++;
    case (a.status)
      hbsag_pkg::ST_OK: n_pixels++;
      hbsag_pkg::ST_BAD_POWER: n_bad++;
      default: n_finished++;
    endcase
    if (a.last) n_last++;
    owed_addrs.push_back(a);
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 30) $display("mismatch at result %0d: %s", n_seen, msg);
  endtask

  task check_addr(scan_addr_t got);
    scan_addr_t want;
    n_seen++;
    if (owed_addrs.size() == 0) begin
      report("result with no step outstanding");
      return;
    end
    want = owed_addrs.pop_front();
    if (got.status !== want.status)
      report($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.src_x !== want.src_x)
      report($sformatf("src_x %0d, want %0d", got.src_x, want.src_x));
    if (got.src_y !== want.src_y)
      report($sformatf("src_y %0d, want %0d", got.src_y, want.src_y));
    if (got.dst_x !== want.dst_x)
      report($sformatf("dst_x %0d, want %0d", got.dst_x, want.dst_x));
    if (got.dst_y !== want.dst_y)
      report($sformatf("dst_y %0d, want %0d", got.dst_y, want.dst_y));
    if (got.last !== want.last)
      report($sformatf("last %0d, want %0d", got.last, want.last));
  endtask
endclass

module testbench;
  localparam int CYCLE_LIMIT = 200000;
  localparam int STEP_TARGET = 1900;

  logic                           clk;
  logic                           rst_n;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [hbsag_pkg::APB_ADDR-1:0] paddr;
  logic [hbsag_pkg::APB_DATA-1:0] pwdata;
  logic [hbsag_pkg::APB_DATA-1:0] prdata;
  logic                           pready;
  bit                             calm;
  int                             cycles;
  int                             settings;

  scan_tracker book;

  hbsag_step_if step_ch ();
  hbsag_addr_if addr_ch ();

  hilbert_block_scan_address_generator_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (step_ch),
    .out_if (addr_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    addr_ch.ready <= calm || ($urandom_range(99) >= 27);
  end

  always @(posedge clk) begin
    scan_addr_t got;
    if (rst_n && addr_ch.valid && addr_ch.ready) begin
      got.src_x = addr_ch.src_x;
      got.src_y = addr_ch.src_y;
      got.dst_x = addr_ch.dst_x;
      got.dst_y = addr_ch.dst_y;
      got.status = addr_ch.status;
      got.last = addr_ch.last;
      book.check_addr(got);
    end
  end

  task cfg_write(logic [hbsag_pkg::REG_SEL-1:0] sel, int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    book.set_reg(sel, value);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task set_geometry(int unsigned iw, int unsigned ih, int unsigned bp,
                    int unsigned ow, int unsigned oh);
    cfg_write(hbsag_pkg::REG_IN_WIDTH, iw);
    cfg_write(hbsag_pkg::REG_IN_HEIGHT, ih);
    cfg_write(hbsag_pkg::REG_BLOCK_POWER, bp);
    cfg_write(hbsag_pkg::REG_OUT_WIDTH, ow);
    cfg_write(hbsag_pkg::REG_OUT_HEIGHT, oh);
    settings++;
  endtask

  task send_step(bit restart);
    while (!calm && $urandom_range(99) < 27) begin
      step_ch.valid <= 1'b0;
      @(posedge clk);
    end
    step_ch.valid <= 1'b1;
    step_ch.restart <= restart;
    do @(posedge clk); while (!step_ch.ready);
    book.take_step(restart);
  endtask

  task settle;
    step_ch.valid <= 1'b0;
    while (book.owed_addrs.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function int unsigned pick_dim(int unsigned usual_max);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 4) return 0;
    if (roll < 6) return 8191;
    if (roll < 8) return 4096;
    if (roll < 10) return $urandom_range(4097, 8191);
    if (roll < 13) return $urandom_range(usual_max + 1, 4096);
    return $urandom_range(1, usual_max);
  endfunction

  task random_phase(int count);
    bit r;
    r = ($urandom_range(99) < 85);
    for (int i = 0; i < count; i++) begin
      send_step(r);
      if (book.finished) r = ($urandom_range(99) < 35);
      else r = ($urandom_range(99) < 3);
    end
    settle();
  endtask

  initial begin
    int unsigned bp;
    int phase;
    book = new();
    cycles = 0;
    settings = 0;
    calm = 0;
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    step_ch.valid <= 1'b0;
    step_ch.restart <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry, first pixel without restart, then finished, then rewind
    send_step(0);
    send_step(0);
    send_step(1);
    send_step(0);
    settle();

    // oversized input clamps, order at its cap
    set_geometry(8191, 8191, 0, 4096, 4096);
    send_step(1);
    send_step(0);
    settle();

    // zero input dimension
    set_geometry(0, 5, 0, 4, 4);
    send_step(1);
    settle();

    // zero output dimension
    set_geometry(5, 5, 0, 0, 3);
    send_step(1);
    settle();

    // block larger than the image
    set_geometry(4, 8, 3, 8, 8);
    send_step(1);
    send_step(0);
    settle();

    // block power above the limit
    set_geometry(16, 16, 13, 4, 4);
    send_step(1);
    settle();
    cfg_write(hbsag_pkg::REG_BLOCK_POWER, 15);
    send_step(0);
    settle();

    // order zero, single pixel
    set_geometry(1, 7, 0, 3, 3);
    send_step(1);
    send_step(0);
    settle();

    // 2x2 blocks, output fills first
    set_geometry(4, 4, 1, 3, 2);
    send_step(1);
    for (int i = 0; i < 6; i++) send_step(0);
    settle();

    // output shrinks under the scan position
    set_geometry(8, 8, 0, 8, 8);
    send_step(1);
    send_step(0);
    send_step(0);
    send_step(0);
    settle();
    cfg_write(hbsag_pkg::REG_OUT_WIDTH, 2);
    send_step(0);
    settle();

    phase = 0;
    while (book.n_steps < STEP_TARGET) begin
      case ($urandom_range(99)) inside
        [0:44]: bp = 0;
        [45:84]: bp = $urandom_range(1, 3);
        default: bp = $urandom_range(4, 15);
      endcase
      set_geometry(pick_dim(20), pick_dim(20), bp, pick_dim(24), pick_dim(24));
      calm = (phase == 4);
      random_phase(calm ? 150 : $urandom_range(20, 120));
      calm = 0;
      phase++;
    end

    $display("summary: %0d steps under %0d geometries: %0d pixels, %0d scan ends",
             book.n_steps, settings, book.n_pixels, book.n_last);
    $display("summary: %0d bad block power, %0d finished, %0d mismatches",
             book.n_bad, book.n_finished, book.errors);
    if (book.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/hbsag_pkg.sv
rtl/hbsag_step_if.sv
rtl/hbsag_addr_if.sv
rtl/hbsag_curve.sv
rtl/hilbert_block_scan_address_generator_unit.sv
tb/sv/testbench.sv
